[rtl/core/multi_click_hold_detector_assert.svh]
// Assertion macros used by the checker file of the click and hold detector.
`ifndef MULTI_CLICK_HOLD_DETECTOR_ASSERT_SVH
`define MULTI_CLICK_HOLD_DETECTOR_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define MCD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, clocked on clk, off during reset.
`define MCD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[rtl/core/mcd_pkg.sv]
// Types and constants of the multi-click and hold detector.
`timescale 1ns / 1ps
package mcd_pkg;

	localparam int TIME_BITS_DEF = 32;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 16;
	localparam int CLICK_W       = 8;

	// item kinds
	localparam logic OP_EVENT = 1'b0;
	localparam logic OP_POLL  = 1'b1;

	// reported event kinds
	localparam logic [1:0] EV_NONE    = 2'd0;
	localparam logic [1:0] EV_CLICKS  = 2'd1;
	localparam logic [1:0] EV_HOLD    = 2'd2;
	localparam logic [1:0] EV_RELEASE = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SILENCE     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RESTART     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_REPEAT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CLICK_WAIT  = 3'd6;

	// register reset values
	localparam logic [15:0] SILENCE_RST     = 16'd20;
	localparam logic [15:0] RESTART_RST     = 16'd1000;
	localparam logic [15:0] HOLD_RST        = 16'd500;
	localparam logic [15:0] HOLD_REPEAT_RST = 16'd100;
	localparam logic [15:0] CLICK_WAIT_RST  = 16'd300;

	localparam logic [CLICK_W-1:0] CLICK_MAX = 8'hFF;

	typedef struct packed {
		logic        op;
		logic [31:0] now_ms;
		logic        pin_level;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         event_kind;
		logic [CLICK_W-1:0] tally;
	} out_item_t;

endpackage

[rtl/core/multi_click_hold_detector.sv]
// Multi-click and hold detector for one push button, one beat per cycle unless stalled.
`timescale 1ns / 1ps
// Takes pin-change events and polls, each stamped with a wrapping millisecond time,
// and answers every beat with exactly one result beat (none, clicks done, hold repeat
// or hold released). One beat is taken every cycle that in_stall is low: the input beat sits
// in a stage-one register, the detector state is read and updated from it as the beat moves
// on, and the result lands in an output register, so a result reaches the output through
// those two registers in turn and is taken at an edge where out_stall is low. While
// a result waits on out_stall, stage one still takes one more beat; in_stall rises once
// both stages are full. Internal times are TIME_BITS wide and all time differences wrap
// at that width. Registers should be written only while idle.
module multi_click_hold_detector #(
	parameter int TIME_BITS = mcd_pkg::TIME_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  mcd_pkg::in_item_t                in_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output mcd_pkg::out_item_t               out_data,
	input  logic                             cfg_wr_en,
	input  logic [mcd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mcd_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import mcd_pkg::*;

	// configuration
	logic        enable_q;
	logic        active_high_q;
	logic [15:0] silence_q;
	logic [15:0] restart_q;
	logic [15:0] hold_q;
	logic [15:0] hold_repeat_q;
	logic [15:0] click_wait_q;

	// detector state
	logic [TIME_BITS-1:0] last_edge_q;
	logic                 last_pressed_q;
	logic [CLICK_W-1:0]   clicks_q;
	logic                 holding_q;
	logic [TIME_BITS-1:0] last_hold_q;

	logic [TIME_BITS-1:0] n_last_edge;
	logic                 n_last_pressed;
	logic [CLICK_W-1:0]   n_clicks;
	logic                 n_holding;
	logic [TIME_BITS-1:0] n_last_hold;

	// pipeline
	logic      v_s1;
	in_item_t  item_s1;
	logic      v_s2;
	out_item_t res_s2;
	out_item_t res;
	logic      adv;
	logic      fire;

	logic [63:0]          now_ext;
	logic [TIME_BITS-1:0] now;
	logic [TIME_BITS-1:0] delta;
	logic [TIME_BITS-1:0] since;
	logic                 pressed;
	logic                 hold_ok;
	logic                 poll_hold;
	logic [CLICK_W-1:0]   poll_clicks;

	assign adv      = !v_s2 || !out_stall;
	assign in_stall = v_s1 && !adv;
	assign fire     = v_s1 && adv;

	assign out_valid = v_s2;
	assign out_data  = res_s2;

	assign now_ext = {32'd0, item_s1.now_ms};
	assign now     = now_ext[TIME_BITS-1:0];
	assign delta   = now - last_edge_q;
	assign since   = now - last_hold_q;
	assign pressed = item_s1.pin_level ^ ~active_high_q;

	always_comb begin
		n_last_edge    = last_edge_q;
		n_last_pressed = last_pressed_q;
		n_clicks       = clicks_q;
		n_holding      = holding_q;
		n_last_hold    = last_hold_q;
		res.event_kind = EV_NONE;
		res.tally      = '0;
		hold_ok        = 1'b0;
		poll_hold      = holding_q;
		poll_clicks    = clicks_q;
		if (enable_q) begin
			if (item_s1.op == OP_EVENT) begin
				n_last_edge = now;
				if (delta >= TIME_BITS'(silence_q)) begin
					// the new level is always the opposite of the stored one
					n_last_pressed = !last_pressed_q;
					if (!last_pressed_q) begin
						if ((clicks_q != '0 || holding_q) &&
							delta > TIME_BITS'(restart_q)) begin
							n_holding = 1'b0;
							n_clicks  = '0;
						end
					end else if (!holding_q) begin
						n_clicks = clicks_q + CLICK_W'(clicks_q != CLICK_MAX);
					end
				end
			end else begin
				hold_ok = !holding_q && pressed && delta >= TIME_BITS'(hold_q);
				if (hold_ok) begin
					poll_hold   = 1'b1;
					poll_clicks = clicks_q + CLICK_W'(clicks_q != CLICK_MAX);
				end else if (holding_q && !pressed) begin
					res.event_kind = EV_RELEASE;
					res.tally      = clicks_q;
					poll_hold      = 1'b0;
					poll_clicks    = '0;
					n_last_pressed = 1'b0;
				end
				n_holding = poll_hold;
				n_clicks  = poll_clicks;
				if (poll_hold) begin
					if (since >= TIME_BITS'(hold_repeat_q)) begin
						res.event_kind = EV_HOLD;
						res.tally      = poll_clicks;
						n_last_hold    = now;
					end
				end else if (poll_clicks != '0 && delta > TIME_BITS'(click_wait_q)) begin
					res.event_kind = EV_CLICKS;
					res.tally      = poll_clicks;
					n_clicks       = '0;
					n_last_pressed = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q      <= 1'b0;
			active_high_q <= 1'b1;
			silence_q     <= SILENCE_RST;
			restart_q     <= RESTART_RST;
			hold_q        <= HOLD_RST;
			hold_repeat_q <= HOLD_REPEAT_RST;
			click_wait_q  <= CLICK_WAIT_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_ENABLE:      enable_q      <= cfg_data[0];
				REG_ACTIVE_HIGH: active_high_q <= cfg_data[0];
				REG_SILENCE:     silence_q     <= cfg_data;
				REG_RESTART:     restart_q     <= cfg_data;
				REG_HOLD:        hold_q        <= cfg_data;
				REG_HOLD_REPEAT: hold_repeat_q <= cfg_data;
				REG_CLICK_WAIT:  click_wait_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_edge_q    <= '0;
			last_pressed_q <= 1'b0;
			clicks_q       <= '0;
			holding_q      <= 1'b0;
			last_hold_q    <= '0;
		end else if (fire) begin
			last_edge_q    <= n_last_edge;
			last_pressed_q <= n_last_pressed;
			clicks_q       <= n_clicks;
			holding_q      <= n_holding;
			last_hold_q    <= n_last_hold;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (!in_stall) begin
				v_s1 <= in_valid;
			end
			if (adv) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= in_data;
		end
		if (fire) begin
			res_s2 <= res;
		end
	end

endmodule

[rtl/core/mcd_checker.sv]
// Port-level checks of the click and hold detector, bound to its top level.
`timescale 1ns / 1ps
`include "multi_click_hold_detector_assert.svh"
module mcd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input mcd_pkg::out_item_t out_data
);
	import mcd_pkg::*;

	// a stalled result beat stays put
	`MCD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

	// input side backs up only behind a waiting result
	`MCD_ASSERT_NOW(a_in_stall_cause, in_stall, out_valid && out_stall)

	// an empty report carries no count
	`MCD_ASSERT_NOW(a_none_zero, out_valid && out_data.event_kind == EV_NONE,
		out_data.tally == '0)

	// a hold always counts itself, and a click report has clicks
	`MCD_ASSERT_NOW(a_count_nonzero,
		out_valid && (out_data.event_kind == EV_HOLD || out_data.event_kind == EV_CLICKS),
		out_data.tally != '0)

endmodule

bind multi_click_hold_detector mcd_checker u_mcd_checker (.*);
